// ===== hdl/mavg_pkg.sv =====
package mavg_pkg;

	localparam int MAX_POINTS   = 128;
	localparam int SAMPLE_W     = 16;
	localparam int CFG_W        = 8;
	localparam int SCALE        = 10;
	localparam int WINDOW_RESET = 10;

	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int WIN_W  = $clog2(MAX_POINTS + 1);
	localparam int PROD_W = SAMPLE_W + $clog2(SCALE);
	localparam int CNT_W  = $clog2(PROD_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIVIDE,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic                rd;
		logic                wr;
		logic                clr;
		logic [ADDR_W-1:0]   addr;
		logic [SAMPLE_W-1:0] wdata;
	} store_req_t;

endpackage

// ===== hdl/moving_average_filter.sv =====
// channel  dir  width  contents
// s_*      in   16     tdata: sample
// m_*      out  16     tdata: average_times_ten
// cfg_*    in   8      window_points, write clears store, total and position
//
// each sample passes through store read, update, 20 steps of the serial divider
// and the output load before its result is valid; the divider sets the rate.
// the result sits in an output register; the next sample is taken meanwhile,
// but no new request is taken until the previous result has been loaded.
// reset and each window write invalidate all 128 store entries at once.
// a stalled result holds the divider until the output register frees up.
module moving_average_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // [15:0] average_times_ten
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);
	import mavg_pkg::*;

	state_t              state_q, state_d;
	logic [CFG_W-1:0]    win_q;
	logic [WIN_W-1:0]    eff_win;
	logic [ADDR_W-1:0]   pos_q;
	logic [ADDR_W-1:0]   cur_pos;
	logic [WIN_W-1:0]    pos_inc;
	logic [SAMPLE_W-1:0] total_q;
	logic [SAMPLE_W-1:0] total_d;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] old_sample;
	logic [PROD_W-1:0]   product;
	logic [PROD_W-1:0]   quotient;
	logic                div_busy;
	logic                div_start;
	logic                out_free;
	logic                out_load;
	logic                accept;
	logic                m_tvalid_q;
	logic [SAMPLE_W-1:0] m_tdata_q;
	store_req_t          store_req;

	always_comb begin
		if (win_q == '0) begin
			eff_win = WIN_W'(1);
		end else if (int'(win_q) > MAX_POINTS) begin
			eff_win = WIN_W'(MAX_POINTS);
		end else begin
			eff_win = WIN_W'(win_q);
		end
	end

	assign cur_pos  = ({1'b0, pos_q} >= WIN_W'(eff_win)) ? '0 : pos_q;
	assign pos_inc  = WIN_W'(cur_pos) + 1'b1;
	assign total_d  = total_q + sample_q - old_sample;
	// times ten as (x << 3) + (x << 1)
	assign product  = (PROD_W'(total_d) << 3) + (PROD_W'(total_d) << 1);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	mavg_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (store_req),
		.old_sample (old_sample)
	);

	mavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (eff_win),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_READ;
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (!div_busy) state_d = out_free ? ST_IDLE : ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready        = 1'b0;
		div_start       = 1'b0;
		out_load        = 1'b0;
		store_req.rd    = 1'b0;
		store_req.wr    = 1'b0;
		store_req.clr   = cfg_wr_en;
		store_req.addr  = cur_pos;
		store_req.wdata = sample_q;
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_READ:   store_req.rd = 1'b1;
			ST_UPDATE: begin
				store_req.wr = 1'b1;
				div_start    = 1'b1;
			end
			ST_DIVIDE: out_load = !div_busy && out_free;
			ST_HOLD:   out_load = out_free;
			default:   s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			win_q      <= CFG_W'(WINDOW_RESET);
			pos_q      <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				win_q   <= cfg_wr_data;
				pos_q   <= '0;
				total_q <= '0;
			end else if (state_q == ST_UPDATE) begin
				total_q <= total_d;
				pos_q   <= (pos_inc >= eff_win) ? '0 : pos_inc[ADDR_W-1:0];
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_tdata;
		end
		if (out_load) begin
			m_tdata_q <= quotient[SAMPLE_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hdl/mavg_store.sv =====
module mavg_store (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mavg_pkg::store_req_t                  req,
	output logic [mavg_pkg::SAMPLE_W-1:0]         old_sample
);
	import mavg_pkg::*;

	logic [SAMPLE_W-1:0]   mem [MAX_POINTS];
	logic [MAX_POINTS-1:0] valid_q;
	logic [SAMPLE_W-1:0]   rdata_q;
	logic                  rvalid_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[req.addr];
		end
	end

	// entries never written since the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				rvalid_q <= valid_q[req.addr];
			end
		end
	end

	assign old_sample = rvalid_q ? rdata_q : '0;

endmodule

// ===== hdl/mavg_div.sv =====
module mavg_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [mavg_pkg::PROD_W-1:0]        dividend,
	input  logic [mavg_pkg::WIN_W-1:0]         divisor,
	output logic                               busy,
	output logic [mavg_pkg::PROD_W-1:0]        quotient
);
	import mavg_pkg::*;

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  quo_q;
	logic [WIN_W-1:0]   rem_q;
	logic [WIN_W-1:0]   div_q;
	logic [WIN_W:0]     trial;
	logic               fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(PROD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= fits ? WIN_W'(trial - {1'b0, div_q}) : trial[WIN_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== verif/moving_average_checker.sv =====
`timescale 1ns / 1ps

module moving_average_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [mavg_pkg::SAMPLE_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [mavg_pkg::SAMPLE_W-1:0] m_tdata,
	input  logic                          cfg_wr_en,
	input  logic [mavg_pkg::CFG_W-1:0]    cfg_wr_data,
	output int                            error_count,
	output int                            averages_pending,
	output int                            averages_checked
);
	import mavg_pkg::*;

	logic [SAMPLE_W-1:0] ring [MAX_POINTS];
	logic [SAMPLE_W-1:0] window_sum;
	logic [CFG_W-1:0]    window_len;
	int unsigned         slot;
	logic [SAMPLE_W-1:0] expected_averages [$];
	int                  mismatches;
	int                  checked;

	// zero and over-range lengths fall back to one and to the store depth
	function automatic int unsigned active_span(input logic [CFG_W-1:0] len);
		if (len == '0)
			return 1;
		if (len > MAX_POINTS)
			return MAX_POINTS;
		return 32'(len);
	endfunction

	function automatic void clear_window();
		foreach (ring[i])
			ring[i] = '0;
		window_sum = '0;
		slot       = 0;
	endfunction

	// pushes one sample into the ring and returns the scaled average it yields
	function automatic logic [SAMPLE_W-1:0] next_average(input logic [SAMPLE_W-1:0] x);
		int unsigned         span;
		logic [SAMPLE_W-1:0] displaced;
		logic [31:0]         quotient;
		span = active_span(window_len);
		if (slot >= span)
			slot = 0;
		displaced  = ring[slot];
		ring[slot] = x;
		window_sum = window_sum + x - displaced;
		// product at full width, only the quotient is cut
		quotient   = (32'(window_sum) * 32'(SCALE)) / span;
		slot       = (slot + 1 >= span) ? 0 : slot + 1;
		return quotient[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			window_len = CFG_W'(WINDOW_RESET);
			clear_window();
			expected_averages.delete();
			mismatches = 0;
			checked    = 0;
		end else begin
			if (cfg_wr_en) begin
				window_len = cfg_wr_data;
				clear_window();
			end
			// results first: a request taken at this edge cannot have its result yet
			if (m_tvalid && m_tready) begin
				if (expected_averages.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected average %0d with no request pending",
						$time, m_tdata);
				end else begin
					want = expected_averages.pop_front();
					checked++;
					if (m_tdata !== want) begin
						mismatches++;
						$display("%0t: average mismatch: expected %0d, actual %0d",
							$time, want, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_averages.push_back(next_average(s_tdata));
		end
		error_count      <= mismatches;
		averages_pending <= expected_averages.size();
		averages_checked <= checked;
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import mavg_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 30;
	localparam int LONG_HOLD    = 400;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_tdata;
	logic                cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]    cfg_wr_data = '0;

	int error_count;
	int averages_pending;
	int averages_checked;
	int samples_sent;
	int windows_set;
	int idle_cycles;
	bit long_hold_done;

	always #5 clk = ~clk;

	moving_average_filter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	moving_average_checker average_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.error_count      (error_count),
		.averages_pending (averages_pending),
		.averages_checked (averages_checked)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(99) < 90)
			return $urandom_range(4, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return SAMPLE_W'($urandom);
		if (roll < 55)
			return '1;
		if (roll < 70)
			return '0;
		if (roll < 85)
			return SAMPLE_W'($urandom_range(255));
		return SAMPLE_W'($urandom_range(16'hFFFF, 16'hFF00));
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] value, input int gap);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		samples_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (averages_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [CFG_W-1:0] len);
		wait_drained();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		windows_set++;
	endtask

	task automatic send_random(input int count);
		int quiet;
		int gap;
		quiet = 0;
		repeat (count) begin
			if (quiet > 0) begin
				quiet--;
				gap = 0;
			end else if ($urandom_range(99) < 4) begin
				quiet = 40;
				gap   = 0;
			end else begin
				gap = ($urandom_range(99) < 50) ? 0 : pick_gap();
			end
			send_sample(pick_sample(), gap);
		end
	endtask

	// receiver: random stalls, stall-free stretches, and one long hold-off
	initial begin
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && samples_sent >= 700) begin
				long_hold_done = 1'b1;
				stall_left     = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (free_left > 0)
					free_left--;
				else if ($urandom_range(99) < 3)
					free_left = 200;
				else if ($urandom_range(99) < 25)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] sweep [10];
		logic [CFG_W-1:0] len;
		int               span;
		sweep = '{8'd128, 8'd2, 8'd1, 8'd0, 8'd255, 8'd129, 8'd3, 8'd200, 8'd127, 8'd64};
		samples_sent   = 0;
		windows_set    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default window of ten: extremes, total wrap-around, position wrap
		send_sample('0, 0);
		repeat (4) send_sample('1, 0);
		send_sample(16'd1, 2);
		send_sample(16'h8000, 0);
		send_sample(16'h5555, 1);
		send_sample(16'hAAAA, 0);
		send_sample('0, 0);
		send_sample(16'h7FFF, 0);
		send_sample('1, 0);

		// window of one: quotient wider than the result
		set_window(8'd1);
		send_sample('1, 0);
		send_sample('0, 0);
		send_sample(16'd1234, 0);

		// zero length acts as one
		set_window(8'd0);
		send_sample('1, 0);
		send_sample(16'd7, 0);

		// over-range length saturates to the store depth
		set_window(8'hFF);
		repeat (3) send_sample('1, 0);

		for (int p = 0; p < 16; p++) begin
			if (p < 10)
				len = sweep[p];
			else if (p < 15)
				len = CFG_W'($urandom_range(MAX_POINTS, 1));
			else
				len = CFG_W'($urandom_range(255));
			set_window(len);
			span = (len == 0) ? 1 : (len > MAX_POINTS ? MAX_POINTS : len);
			send_random(span >= 64 ? 150 : 80);
		end

		// back to the reset length at the end
		set_window(CFG_W'(WINDOW_RESET));
		send_random(40);

		wait_drained();
		$display("sent %0d samples across %0d window writes, %0d averages checked",
			samples_sent, windows_set, averages_checked);
		$display("window lengths swept from zero to full scale, long output stall applied");
		if (error_count == 0 && averages_pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mavg_pkg.sv
hdl/mavg_store.sv
hdl/mavg_div.sv
hdl/moving_average_filter.sv
verif/moving_average_checker.sv
verif/testbench.sv
